// File: rtl/cta_pkg.sv
// Shared types and constants for the comet trail LED animator.
package cta_pkg;

    localparam int CNT_W = 7;
    localparam int IDX_W = 6;
    localparam int CH_W  = 8;
    localparam int INT_W = 10;
    localparam int PH_W  = 5;

    localparam logic [1:0] ST_AVAILABLE = 2'd0;
    localparam logic [1:0] ST_CHARGING  = 2'd1;
    localparam logic [1:0] ST_ERROR     = 2'd2;
    localparam logic [1:0] ST_CONFIG    = 2'd3;

    localparam logic REG_LED_COUNT      = 1'b0;
    localparam logic REG_FRAME_INTERVAL = 1'b1;

    localparam logic [CNT_W-1:0] LED_COUNT_RST      = 7'd16;
    localparam logic [INT_W-1:0] FRAME_INTERVAL_RST = 10'd50;

    localparam logic [PH_W-1:0] BLINK_HALF = 5'd10;
    localparam logic [PH_W-1:0] BLINK_LAST = 5'd19;
    localparam logic [CH_W-1:0] FULL       = 8'hFF;

    typedef struct packed {
        logic tick_count;
        logic frame_start;
        logic load_pixel;
        logic next_pixel;
    } cta_cmd_t;

    typedef struct packed {
        logic frame_due;
        logic last_pixel;
    } cta_stat_t;

endpackage

// File: rtl/comet_trail_led_animator.sv
// A tick that fires no frame only advances the tick count; a firing tick passes through the
// pixel-load state, where LED 0 is loaded, to the output state, where LED 0 is shown.
// Each LED takes a pixel load, then an output transaction held until m_tready; the next LED loads only after that.
// No input is taken until the last LED of a frame is delivered.
// Reset (rst_n, async low): led_count 16, frame_interval 50, tick count, head and blink cleared.
// Top level of the comet trail LED animator.
module comet_trail_led_animator
    import cta_pkg::*;
#(
    parameter int MAX_LEDS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] status
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [5:0] led_index, [13:6] red, [21:14] green, [29:22] blue
    output logic        m_tlast
);

    cta_cmd_t         cmd;
    cta_stat_t        stat;
    logic [IDX_W-1:0] led_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;

    cta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    cta_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_status  (s_tdata[1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .led_index (led_index),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .frame_end (m_tlast)
    );

    assign m_tdata = {2'b00, blue, green, red, led_index};

endmodule

// File: rtl/cta_ctrl.sv
// Sequencer for tick handling and per-LED output transactions.
module cta_ctrl
    import cta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      m_tready,
    input  cta_stat_t stat,
    output cta_cmd_t  cmd,
    output logic      s_tready,
    output logic      m_tvalid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (stat.frame_due)
                    begin
                        cmd.frame_start = 1'b1;
                        state_next      = S_PREP;
                    end
                    else
                    begin
                        cmd.tick_count = 1'b1;
                    end
                end
            end
            S_PREP:
            begin
                cmd.load_pixel = 1'b1;
                state_next     = S_SEND;
            end
            S_SEND:
            begin
                if (m_tready)
                begin
                    if (stat.last_pixel)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_pixel = 1'b1;
                        state_next     = S_PREP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_SEND);

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output transactions overlap");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && stat.last_pixel) |=> s_tready)
        else $error("frame did not return to idle after last pixel");

    a_load_before_send: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.load_pixel))
        else $error("pixel shown without being loaded");
`endif

endmodule

// File: rtl/cta_datapath.sv
// Tick counter, animation state and pixel colour datapath.
module cta_datapath
    import cta_pkg::*;
#(
    parameter int MAX_LEDS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [INT_W-1:0] cfg_wdata,
    input  logic [1:0]       s_status,
    input  cta_cmd_t         cmd,
    output cta_stat_t        stat,
    output logic [IDX_W-1:0] led_index,
    output logic [CH_W-1:0]  red,
    output logic [CH_W-1:0]  green,
    output logic [CH_W-1:0]  blue,
    output logic             frame_end
);

    localparam logic [CNT_W-1:0] N_MAX =
        (MAX_LEDS >= 127) ? {CNT_W{1'b1}} : CNT_W'(MAX_LEDS);

    logic [CNT_W-1:0] led_count_reg;
    logic [INT_W-1:0] frame_interval_reg;
    logic [INT_W-1:0] elapsed_reg;
    logic [CNT_W-1:0] head_reg;
    logic [PH_W-1:0]  blink_reg;
    logic [1:0]       mode_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [IDX_W-1:0] led_index_reg;
    logic [CH_W-1:0]  red_reg;
    logic [CH_W-1:0]  green_reg;
    logic [CH_W-1:0]  blue_reg;
    logic             frame_end_reg;

    logic [CNT_W-1:0] n_cur;
    logic [CNT_W:0]   head_inc;
    logic [CNT_W-1:0] head_next;
    logic [PH_W-1:0]  blink_next;
    logic [CNT_W:0]   trail_dist;
    logic [CNT_W:0]   shift;
    logic [CH_W-1:0]  level;
    logic             blink_on;
    logic [CH_W-1:0]  red_next;
    logic [CH_W-1:0]  green_next;
    logic [CH_W-1:0]  blue_next;

    always_comb
    begin
        if (led_count_reg == '0)
        begin
            n_cur = CNT_W'(1);
        end
        else if (led_count_reg > N_MAX)
        begin
            n_cur = N_MAX;
        end
        else
        begin
            n_cur = led_count_reg;
        end
    end

    assign head_inc   = {1'b0, head_reg} + (CNT_W+1)'(1);
    assign head_next  = (head_inc >= {1'b0, n_cur}) ? '0 : head_inc[CNT_W-1:0];
    assign blink_next = (blink_reg == BLINK_LAST) ? '0 : blink_reg + PH_W'(1);

    // distance behind the head, wrapping around the strip
    always_comb
    begin
        if (head_reg >= idx_reg)
        begin
            trail_dist = {1'b0, head_reg} - {1'b0, idx_reg};
        end
        else
        begin
            trail_dist = {1'b0, head_reg} + {1'b0, n_reg} - {1'b0, idx_reg};
        end
        shift = (idx_reg == head_reg) ? '0 : trail_dist + (CNT_W+1)'(1);
        level = (shift >= (CNT_W+1)'(8)) ? '0 : (FULL >> shift[2:0]);
    end

    assign blink_on = (blink_reg < BLINK_HALF);

    always_comb
    begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        case (mode_reg)
            ST_AVAILABLE: blue_next  = level;
            ST_CHARGING:  green_next = level;
            ST_ERROR:     red_next   = blink_on ? level : '0;
            default:
            begin
                red_next  = FULL;
                blue_next = FULL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg      <= LED_COUNT_RST;
            frame_interval_reg <= FRAME_INTERVAL_RST;
            elapsed_reg        <= '0;
            head_reg           <= '0;
            blink_reg          <= '0;
            mode_reg           <= ST_AVAILABLE;
            n_reg              <= CNT_W'(1);
            idx_reg            <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LED_COUNT:      led_count_reg      <= cfg_wdata[CNT_W-1:0];
                    REG_FRAME_INTERVAL: frame_interval_reg <= cfg_wdata;
                    default:            ;
                endcase
            end
            if (cmd.tick_count)
            begin
                elapsed_reg <= elapsed_reg + INT_W'(1);
            end
            if (cmd.frame_start)
            begin
                elapsed_reg <= '0;
                head_reg    <= head_next;
                blink_reg   <= blink_next;
                mode_reg    <= s_status;
                n_reg       <= n_cur;
                idx_reg     <= '0;
            end
            if (cmd.next_pixel)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            led_index_reg <= idx_reg[IDX_W-1:0];
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            frame_end_reg <= ({1'b0, idx_reg} + (CNT_W+1)'(1)) == {1'b0, n_reg};
        end
    end

    assign stat.frame_due  = (elapsed_reg >= frame_interval_reg);
    assign stat.last_pixel = frame_end_reg;
    assign led_index       = led_index_reg;
    assign red             = red_reg;
    assign green           = green_reg;
    assign blue            = blue_reg;
    assign frame_end       = frame_end_reg;

endmodule
